// ===== src/insertion_sorter_macros.svh =====
// Assertion macros for the insertion sorter.
`ifndef INSERTION_SORTER_MACROS_SVH
`define INSERTION_SORTER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ISR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("insertion_sorter: same-cycle check failed");
`define ISR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("insertion_sorter: next-cycle check failed");
`else
`define ISR_ASSERT_SAME(lbl, ante, cons)
`define ISR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/isr_pkg.sv =====
// Shared types and the value width constant of the insertion sorter.
package isr_pkg;

    localparam int VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic insert;
        logic shift_out;
    } cell_ctrl_t;

endpackage

// ===== src/isr_cell.sv =====
// One compare-and-shift cell of the sorting chain.
module isr_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  isr_pkg::cell_ctrl_t ctrl,
    input  isr_pkg::value_t    item,
    input  isr_pkg::value_t    left_value,
    input  logic               left_occ,
    input  logic               left_greater,
    input  isr_pkg::value_t    right_value,
    input  logic               right_occ,
    output isr_pkg::value_t    value_q,
    output logic               occ_q,
    output logic               greater
);

    isr_pkg::value_t value_reg;
    isr_pkg::value_t value_next;
    logic            occ_reg;
    logic            occ_next;

    // empty cells count as greater than any item
    assign greater = !occ_reg || (value_reg > item);

    always_comb
    begin
        value_next = value_reg;
        occ_next   = occ_reg;
        if (ctrl.insert)
        begin
            occ_next = left_occ;
            if (greater)
            begin
                value_next = left_greater ? left_value : item;
            end
        end
        else if (ctrl.shift_out)
        begin
            occ_next   = right_occ;
            value_next = right_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value_q = value_reg;
    assign occ_q   = occ_reg;

endmodule

// ===== src/insertion_sorter.sv =====
// Insertion sorter: inserts one input beat per cycle in place in a chain of DEPTH cells.
// Input is stalled while a set drains; draining pops one stored value per cycle,
// paced by the output register, which takes a value while empty or not stalled.
// Accepting the last beat moves the state to drain; the first result is then registered.
// Reset (rst_n, async low) empties the chain and clears the overflow flag.
`include "insertion_sorter_macros.svh"
module insertion_sorter #(
    parameter int DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic signed [isr_pkg::VALUE_W-1:0] value,
    input  logic                        last,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic signed [isr_pkg::VALUE_W-1:0] sorted_value,
    output logic                        end_of_set,
    output logic                        dropped
);

    typedef enum logic {ST_FILL, ST_DRAIN} state_t;

    state_t              state_reg;
    state_t              state_next;
    logic                overflow_reg;
    logic                overflow_next;
    logic                result_valid_reg;
    logic                result_valid_next;
    isr_pkg::value_t     sorted_value_reg;
    isr_pkg::value_t     sorted_value_next;
    logic                end_reg;
    logic                end_next;
    logic                dropped_reg;
    logic                dropped_next;

    isr_pkg::value_t     cell_value [DEPTH];
    logic [DEPTH-1:0]    cell_occ;
    logic [DEPTH-1:0]    cell_greater;
    isr_pkg::cell_ctrl_t ctrl;

    logic accept;
    logic full;
    logic pop;

    assign item_stall = (state_reg == ST_DRAIN);
    assign accept     = item_valid && !item_stall;
    assign full       = cell_occ[DEPTH-1];
    assign pop        = (state_reg == ST_DRAIN) && (!result_valid_reg || !result_stall);

    assign ctrl.insert    = accept && !full;
    assign ctrl.shift_out = pop;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        isr_pkg::value_t lv;
        logic            lo;
        logic            lg;
        isr_pkg::value_t rv;
        logic            ro;

        if (i == 0)
        begin : g_head
            assign lv = value;
            assign lo = 1'b1;
            assign lg = 1'b0;
        end
        else
        begin : g_mid
            assign lv = cell_value[i-1];
            assign lo = cell_occ[i-1];
            assign lg = cell_greater[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign rv = cell_value[i];
            assign ro = 1'b0;
        end
        else
        begin : g_body
            assign rv = cell_value[i+1];
            assign ro = cell_occ[i+1];
        end

        isr_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .item         (value),
            .left_value   (lv),
            .left_occ     (lo),
            .left_greater (lg),
            .right_value  (rv),
            .right_occ    (ro),
            .value_q      (cell_value[i]),
            .occ_q        (cell_occ[i]),
            .greater      (cell_greater[i])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        overflow_next     = overflow_reg;
        result_valid_next = result_valid_reg && result_stall;
        sorted_value_next = sorted_value_reg;
        end_next          = end_reg;
        dropped_next      = dropped_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (pop)
                begin
                    result_valid_next = 1'b1;
                    sorted_value_next = cell_value[0];
                    end_next          = !cell_occ[1];
                    dropped_next      = overflow_reg;
                    if (!cell_occ[1])
                    begin
                        state_next    = ST_FILL;
                        overflow_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_FILL;
            overflow_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            sorted_value_reg <= '0;
            end_reg          <= 1'b0;
            dropped_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            overflow_reg     <= overflow_next;
            result_valid_reg <= result_valid_next;
            sorted_value_reg <= sorted_value_next;
            end_reg          <= end_next;
            dropped_reg      <= dropped_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign end_of_set   = end_reg;
    assign dropped      = dropped_reg;

    // occupied cells always form a prefix of the chain
    `ISR_ASSERT_SAME(a_occ_prefix, 1'b1, $onehot({1'b0, cell_occ} + {{DEPTH{1'b0}}, 1'b1}))
    `ISR_ASSERT_NEXT(a_last_drains, accept && last, state_reg == ST_DRAIN)
    `ISR_ASSERT_SAME(a_drain_nonempty, state_reg == ST_DRAIN, cell_occ[0])
    `ISR_ASSERT_NEXT(a_final_pop_empties, pop && !cell_occ[1], cell_occ == '0 && !overflow_reg)

endmodule

// ===== tb/isr_checker.sv =====
// Checker for the insertion sorter: predicts each sorted set and compares the result beats.
module isr_checker #(
    parameter int DEPTH = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  logic            item_stall,
    input  isr_pkg::value_t value,
    input  logic            last,
    input  logic            result_valid,
    input  logic            result_stall,
    input  isr_pkg::value_t sorted_value,
    input  logic            end_of_set,
    input  logic            dropped,
    output int              mismatches,
    output int              pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        isr_pkg::value_t v;
        logic            eos;
        logic            drop;
    } sorted_beat_t;

    isr_pkg::value_t ordered [DEPTH];
    int              fill;
    logic            overflowed;
    sorted_beat_t    expected_beats [$];

    task automatic take_value(isr_pkg::value_t v, logic l);
        int pos;
        if (fill < DEPTH)
        begin
            pos = fill;
            // equal values stay behind earlier ones
            while (pos > 0 && ordered[pos-1] > v)
            begin
                ordered[pos] = ordered[pos-1];
                pos--;
            end
            ordered[pos] = v;
            fill++;
        end
        else
        begin
            overflowed = 1'b1;
        end
        if (l)
        begin
            for (int k = 0; k < fill; k++)
            begin
                expected_beats.push_back(sorted_beat_t'{ordered[k], k == fill - 1, overflowed});
            end
            fill = 0;
            overflowed = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sorted_beat_t want;
        if (!rst_n)
        begin
            fill = 0;
            overflowed = 1'b0;
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                take_value(value, last);
            if (result_valid && !result_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("unexpected result beat: sorted_value %0d", sorted_value);
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (sorted_value !== want.v)
                    begin
                        $error("sorted_value: expected %0d, actual %0d", want.v, sorted_value);
                        mismatches++;
                    end
                    if (end_of_set !== want.eos)
                    begin
                        $error("end_of_set: expected %0b, actual %0b", want.eos, end_of_set);
                        mismatches++;
                    end
                    if (dropped !== want.drop)
                    begin
                        $error("dropped: expected %0b, actual %0b", want.drop, dropped);
                        mismatches++;
                    end
                end
            end
            pending = expected_beats.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the insertion sorter testbench: clock, reset, set stimulus, output stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SORT_DEPTH  = 64;
    localparam int ITEM_TARGET = 410;

    typedef enum int {SPREAD_FULL, SPREAD_NARROW, SPREAD_EDGES} spread_t;

    logic            clk;
    logic            rst_n;
    logic            item_valid;
    logic            item_stall;
    isr_pkg::value_t value;
    logic            last;
    logic            result_valid;
    logic            result_stall;
    isr_pkg::value_t sorted_value;
    logic            end_of_set;
    logic            dropped;

    int mismatches;
    int pending;
    int items_sent;
    int feed_calm;
    int drain_calm;

    insertion_sorter #(.DEPTH(SORT_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sorted_value (sorted_value),
        .end_of_set   (end_of_set),
        .dropped      (dropped)
    );

    isr_checker #(.DEPTH(SORT_DEPTH)) sort_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .value        (value),
        .last         (last),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sorted_value (sorted_value),
        .end_of_set   (end_of_set),
        .dropped      (dropped),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // idle cycles before the next beat; occasional stretches with none
    function automatic int draw_wait(inout int calm);
        int n = 0;
        if (calm > 0)
            calm--;
        else if ($urandom_range(0, 7) == 0)
            calm = $urandom_range(10, 30);
        else
            n = $urandom_range(0, 6);
        return n;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(isr_pkg::value_t v, logic l);
        int gap;
        gap = draw_wait(feed_calm);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        value <= v;
        last <= l;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_set(int size, spread_t spread);
        isr_pkg::value_t v;
        for (int i = 0; i < size; i++)
        begin
            case (spread)
                SPREAD_FULL:
                    v = $urandom;
                SPREAD_NARROW:
                begin
                    v = $urandom_range(0, 6);
                    v = v - 3;
                end
                default:
                begin
                    case ($urandom_range(0, 5))
                        0: v = 32'sh8000_0000;
                        1: v = 32'sh8000_0001;
                        2: v = 32'sh7fff_ffff;
                        3: v = 32'sh7fff_fffe;
                        4: v = -1;
                        default: v = 0;
                    endcase
                end
            endcase
            send_item(v, i == size - 1);
        end
    endtask

    initial
    begin
        int pick;
        int size;
        rst_n = 1'b0;
        item_valid = 1'b0;
        value = '0;
        last = 1'b0;
        feed_calm = 0;
        items_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-value sets at both ends of the range
        send_item(32'sh7fff_ffff, 1'b1);
        send_item(32'sh8000_0000, 1'b1);
        // extremes mixed with duplicates
        send_item(5, 1'b0);
        send_item(-1, 1'b0);
        send_item(0, 1'b0);
        send_item(32'sh7fff_ffff, 1'b0);
        send_item(32'sh8000_0000, 1'b0);
        send_item(5, 1'b0);
        send_item(-1, 1'b1);
        // all equal
        send_item(3, 1'b0);
        send_item(3, 1'b0);
        send_item(3, 1'b1);
        // descending, then ascending
        send_item(4, 1'b0);
        send_item(3, 1'b0);
        send_item(2, 1'b0);
        send_item(1, 1'b1);
        send_item(1, 1'b0);
        send_item(2, 1'b0);
        send_item(3, 1'b1);

        // store overflow with last dropped, then an exactly full store
        send_set(SORT_DEPTH + 3, SPREAD_FULL);
        send_set(SORT_DEPTH, SPREAD_NARROW);

        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                size = $urandom_range(SORT_DEPTH - 2, SORT_DEPTH + 6);
            else if (pick < 3)
                size = 1;
            else
                size = $urandom_range(2, 12);
            send_set(size, spread_t'($urandom_range(0, 2)));
        end
        item_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int hold;
        result_stall = 1'b0;
        drain_calm = 0;
        @(posedge rst_n);
        forever
        begin
            hold = draw_wait(drain_calm);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
            @(negedge clk);
        end
    end

endmodule
